// ===== hdl/tcq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-class tag queue package
// Shared constants and control types for the two-class tag queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int TAG_WIDTH_DEF   = 32;
   localparam int PORT_TAG_WIDTH  = 32;
   localparam int RUN_WIDTH       = 8;

   localparam logic [RUN_WIDTH-1:0] SWITCH_LEN_RESET = 8'd4;
   localparam logic [RUN_WIDTH-1:0] RUN_MAX          = 8'hFF;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_GET    = 1'b1;
   localparam logic CLASS_HIGH  = 1'b0;
   localparam logic CLASS_LOW   = 1'b1;

   typedef struct packed {
      logic push;
      logic pop;
   } tcq_qcmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic empty_next;
   } tcq_qstat_type;

endpackage
`default_nettype wire

// ===== hdl/tcq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tcq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/tcq_ptr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Queue pointer unit
// Holds the head index and fill count of one circular tag queue and works
// out the read and write addresses of its storage.
// ----------------------------------------------------------------------------
module tcq_ptr
   import tcq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   input  wire  tcq_qcmd_type             cmd,
   output logic       [$clog2(DEPTH)-1:0] head,
   output logic       [$clog2(DEPTH)-1:0] wr_addr,
   output tcq_qstat_type                  stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [AW:0]   tail_sum;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (cmd.push && !cmd.pop) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop && !cmd.push) begin
         count_in = count_ff - CW'(1);
      end
   end

   // A write into a full queue lands on the head, which is evicted at once.
   assign tail_sum = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign wr_addr  = (tail_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);
   assign head     = head_ff;

   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CW'(DEPTH));
   assign stat.empty_next = (count_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && stat.empty))
      else $error("tcq_ptr: pop from an empty queue");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("tcq_ptr: fill count beyond depth");

   a_pop_moves_head : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> head_ff != $past(head_ff))
      else $error("tcq_ptr: head did not advance on pop");
`endif

endmodule
`default_nettype wire

// ===== hdl/two_class_queue_with_switch_limit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-class tag queue with a high-class grant limit
// The result word of an accepted command appears in the next cycle.
// Throughput: one command per cycle; busy is high during reset and the cycle
// after it. The arbitration and pointer update are done in the accept cycle,
// and the tag comes from the registered read port of each queue's storage.
// Reset clears both queues and the grant run and sets switch length to 4.
// ----------------------------------------------------------------------------
module two_class_queue_with_switch_limit
   import tcq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
   input  wire  logic                      clock,
   input  wire  logic                      reset,
   input  wire  logic                      start,
   output logic                            busy,
   input  wire  logic                      req_func,
   input  wire  logic                      req_priority_class,
   input  wire  logic [PORT_TAG_WIDTH-1:0] req_packet_tag,
   output logic                            rsp_strobe,
   output logic                            rsp_out_valid,
   output logic       [PORT_TAG_WIDTH-1:0] rsp_out_tag,
   output logic                            rsp_evicted,
   output logic                            rsp_served_low,
   output logic                            rsp_all_empty,
   input  wire  logic                      csr_we,
   input  wire  logic [RUN_WIDTH-1:0]      csr_wdata
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic                 busy_ff;
   logic [RUN_WIDTH-1:0] switch_len_ff;
   logic [RUN_WIDTH-1:0] run_ff;
   logic [RUN_WIDTH-1:0] run_in;

   logic strobe_ff,   strobe_in;
   logic valid_ff,    valid_in;
   logic evicted_ff,  evicted_in;
   logic low_ff,      low_in;
   logic empty_ff,    empty_in;

   logic accept;
   logic is_insert;
   logic is_get;
   logic get_ok;
   logic sel_high;

   tcq_qcmd_type  hi_cmd;
   tcq_qcmd_type  lo_cmd;
   tcq_qstat_type hi_stat;
   tcq_qstat_type lo_stat;

   logic [AW-1:0]        hi_head;
   logic [AW-1:0]        hi_wr_addr;
   logic [AW-1:0]        lo_head;
   logic [AW-1:0]        lo_wr_addr;
   logic [TAG_WIDTH-1:0] wr_tag;
   logic [TAG_WIDTH-1:0] hi_rd_data;
   logic [TAG_WIDTH-1:0] lo_rd_data;
   logic [TAG_WIDTH-1:0] rd_sel;
   logic [63:0]          tag_ext;
   logic [63:0]          rd_ext;

   assign accept    = start && !busy_ff;
   assign is_insert = accept && (req_func == FUNC_INSERT);
   assign is_get    = accept && (req_func == FUNC_GET);
   assign get_ok    = is_get && !(hi_stat.empty && lo_stat.empty);
   assign sel_high  = !hi_stat.empty && ((run_ff < switch_len_ff) || lo_stat.empty);

   always_comb begin
      hi_cmd.push = is_insert && (req_priority_class == CLASS_HIGH);
      lo_cmd.push = is_insert && (req_priority_class == CLASS_LOW);
      hi_cmd.pop  = (hi_cmd.push && hi_stat.full) || (get_ok && sel_high);
      lo_cmd.pop  = (lo_cmd.push && lo_stat.full) || (get_ok && !sel_high);
   end

   always_comb begin
      run_in = run_ff;
      if (get_ok) begin
         if (sel_high) begin
            run_in = (run_ff == RUN_MAX) ? run_ff : run_ff + RUN_WIDTH'(1);
         end else begin
            run_in = '0;
         end
      end
   end

   assign strobe_in  = accept;
   assign valid_in   = get_ok;
   assign evicted_in = (hi_cmd.push && hi_stat.full) || (lo_cmd.push && lo_stat.full);
   assign low_in     = is_insert ? (req_priority_class == CLASS_LOW) : !sel_high;
   assign empty_in   = hi_stat.empty_next && lo_stat.empty_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         switch_len_ff <= SWITCH_LEN_RESET;
         run_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         run_ff    <= run_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            switch_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_ff   <= valid_in;
      evicted_ff <= evicted_in;
      low_ff     <= low_in;
      empty_ff   <= empty_in;
   end

   tcq_ptr #(
      .DEPTH (QUEUE_DEPTH)
   ) u_hi_ptr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hi_cmd),
      .head    (hi_head),
      .wr_addr (hi_wr_addr),
      .stat    (hi_stat)
   );

   tcq_ptr #(
      .DEPTH (QUEUE_DEPTH)
   ) u_lo_ptr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (lo_cmd),
      .head    (lo_head),
      .wr_addr (lo_wr_addr),
      .stat    (lo_stat)
   );

   assign tag_ext = 64'(req_packet_tag);
   assign wr_tag  = tag_ext[TAG_WIDTH-1:0];

   tcq_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_hi_ram (
      .clock      (clock),
      .wr_en      (hi_cmd.push),
      .wr_addr    (hi_wr_addr),
      .wr_data    (wr_tag),
      .rd_addr    (hi_head),
      .rd_data_ff (hi_rd_data)
   );

   tcq_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_lo_ram (
      .clock      (clock),
      .wr_en      (lo_cmd.push),
      .wr_addr    (lo_wr_addr),
      .wr_data    (wr_tag),
      .rd_addr    (lo_head),
      .rd_data_ff (lo_rd_data)
   );

   assign rd_sel = low_ff ? lo_rd_data : hi_rd_data;
   assign rd_ext = (valid_ff || evicted_ff) ? 64'(rd_sel) : '0;

   assign busy           = busy_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_out_valid  = strobe_ff && valid_ff;
   assign rsp_out_tag    = rd_ext[PORT_TAG_WIDTH-1:0];
   assign rsp_evicted    = strobe_ff && evicted_ff;
   assign rsp_served_low = strobe_ff && valid_ff && low_ff;
   assign rsp_all_empty  = strobe_ff && empty_ff;

`ifndef SYNTHESIS
   a_word_per_command : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_strobe == $past(accept))
      else $error("top: result word does not match accepted command");

   a_valid_or_evicted : assert property (@(posedge clock) disable iff (reset)
      !(rsp_out_valid && rsp_evicted))
      else $error("top: a word both returned and evicted a tag");

   a_low_needs_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_served_low |-> rsp_out_valid)
      else $error("top: low class reported without a returned tag");

   a_empty_get_invalid : assert property (@(posedge clock) disable iff (reset)
      (is_get && hi_stat.empty && lo_stat.empty) |=> (rsp_all_empty && !rsp_out_valid))
      else $error("top: get on empty queues returned a tag");
`endif

endmodule
`default_nettype wire
